@@ src/pva_pkg.sv @@
// pva_pkg: shared constants, codes and control/status structs of the voice allocator.
// Used by pva_ctrl, pva_datapath and poly_voice_allocator_unit; no dependencies.
`timescale 1ns / 1ps

package pva_pkg;

	localparam int MAX_VOICES = 32;
	localparam int IDX_W      = $clog2(MAX_VOICES);
	localparam int CNT_W      = $clog2(MAX_VOICES + 1);

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 7;
	localparam int NOW_W   = 31;
	localparam int VIDX_W  = 5;
	localparam int LABEL_W = 9;
	localparam int PITCH_W = 7;
	localparam int VEL_W   = 7;
	localparam int NV_W    = 6;
	localparam int BASE_W  = 8;
	localparam int PCNT_W  = 6;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [NV_W-1:0]   NUM_VOICES_RST = NV_W'(2);
	localparam logic [PCNT_W-1:0] PCNT_MAX       = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_NOTE   = 2'd0,
		CMD_SETVEL = 2'd1,
		CMD_ALLOFF = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_VOICES = 2'd0,
		REG_VOICE_BASE = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic cap;
		logic set_vel;
		logic idx_clr;
		logic idx_inc;
		logic old_clr;
		logic old_upd;
		logic rel_cur;
		logic rel_old;
		logic slot_cur;
		logic start;
		logic flush;
		logic clr_count;
	} ctrl_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic val_zero;
		logic nv_zero;
		logic pv_zero;
		logic idx_end;
		logic hit_match;
		logic hit_free;
		logic emit_ok;
	} dp_status_t;

endpackage

@@ src/pva_ctrl.sv @@
// pva_ctrl: sequencer of the voice allocator (match, free, oldest scans, emits, flush).
// Depends on pva_pkg; drives pva_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps

module pva_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pva_pkg::dp_status_t st,
	output pva_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MATCH,
		ST_FREE,
		ST_OLD,
		ST_STEAL,
		ST_START,
		ST_ALLOFF,
		ST_FLUSH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.idx_clr = 1'b1;
				case (st.cmd)
					pva_pkg::CMD_SETVEL: begin
						cmd.set_vel = 1'b1;
						state_d     = ST_IDLE;
					end
					pva_pkg::CMD_ALLOFF: state_d = ST_ALLOFF;
					pva_pkg::CMD_NOTE: begin
						if (st.nv_zero || st.val_zero)
							state_d = ST_IDLE;
						else
							state_d = ST_MATCH;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_MATCH: begin
				if (st.idx_end) begin
					cmd.idx_clr = 1'b1;
					state_d     = st.pv_zero ? ST_FLUSH : ST_FREE;
				end else if (st.hit_match) begin
					if (st.emit_ok) begin
						cmd.rel_cur = 1'b1;
						cmd.idx_clr = 1'b1;
						state_d     = st.pv_zero ? ST_FLUSH : ST_FREE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_FREE: begin
				if (st.idx_end) begin
					cmd.idx_clr = 1'b1;
					cmd.old_clr = 1'b1;
					state_d     = ST_OLD;
				end else if (st.hit_free) begin
					cmd.slot_cur = 1'b1;
					state_d      = ST_START;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_OLD: begin
				if (st.idx_end) begin
					state_d = ST_STEAL;
				end else begin
					cmd.old_upd = 1'b1;
					cmd.idx_inc = 1'b1;
				end
			end
			ST_STEAL: begin
				if (st.emit_ok) begin
					cmd.rel_old = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				if (st.emit_ok) begin
					cmd.start = 1'b1;
					state_d   = ST_FLUSH;
				end
			end
			ST_ALLOFF: begin
				if (st.idx_end) begin
					cmd.clr_count = 1'b1;
					state_d       = ST_FLUSH;
				end else if (!st.hit_free) begin
					if (st.emit_ok) begin
						cmd.rel_cur = 1'b1;
						cmd.idx_inc = 1'b1;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (st.emit_ok) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/pva_datapath.sv @@
// pva_datapath: voice pitch/start registers, scan index, oldest tracking, result queue.
// Depends on pva_pkg; commanded by pva_ctrl.
`timescale 1ns / 1ps

module pva_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [pva_pkg::S_DATA_W-1:0]        s_tdata,
	input  logic                                cfg_we,
	input  logic [pva_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pva_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  pva_pkg::ctrl_cmd_t                  cmd,
	output pva_pkg::dp_status_t                 st,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pva_pkg::M_DATA_W-1:0]        m_tdata,
	output logic                                m_tlast
);

	localparam int IW = pva_pkg::IDX_W;
	localparam int CW = pva_pkg::CNT_W;
	localparam int PW = pva_pkg::PITCH_W;
	localparam int TW = pva_pkg::NOW_W;

	// configuration
	logic [pva_pkg::NV_W-1:0]   num_voices_q;
	logic [pva_pkg::BASE_W-1:0] voice_base_q;

	// captured item
	pva_pkg::cmd_t                cmd_q;
	logic [pva_pkg::VALUE_W-1:0]  val_q;
	logic [TW-1:0]                now_q;
	logic [CW-1:0]                nv_q;

	// voice state
	logic [PW-1:0]                pitch_q [pva_pkg::MAX_VOICES];
	logic [TW-1:0]                start_q [pva_pkg::MAX_VOICES];
	logic [pva_pkg::VEL_W-1:0]    pvel_q;
	logic [pva_pkg::PCNT_W-1:0]   pcnt_q;

	// scan
	logic [CW-1:0]                idx_q;
	logic [IW-1:0]                slot_q;
	logic                         have1_q, have2_q;
	logic [IW-1:0]                o1_q, o2_q;
	logic [TW-1:0]                t1_q, t2_q;
	logic [PW-1:0]                p1_q, p2_q;

	// result holding and output registers
	logic                         pend_q;
	logic [pva_pkg::VIDX_W-1:0]   pend_idx_q;
	logic [pva_pkg::LABEL_W-1:0]  pend_label_q;
	logic [PW-1:0]                pend_pitch_q;
	logic [pva_pkg::VEL_W-1:0]    pend_vel_q;
	logic                         out_valid_q;
	logic                         out_last_q;
	logic [pva_pkg::VIDX_W-1:0]   out_idx_q;
	logic [pva_pkg::LABEL_W-1:0]  out_label_q;
	logic [PW-1:0]                out_pitch_q;
	logic [pva_pkg::VEL_W-1:0]    out_vel_q;

	logic [IW-1:0]                cur;
	logic [PW-1:0]                cur_pitch;
	logic [TW-1:0]                cur_start;
	logic [IW-1:0]                sel_o;
	logic [PW-1:0]                sel_p;
	logic                         out_free, emit, push;
	logic [IW-1:0]                e_idx;
	logic [PW-1:0]                e_pitch;
	logic [pva_pkg::VEL_W-1:0]    e_vel;
	logic [CW-1:0]                nv_in;

	assign cur       = idx_q[IW-1:0];
	assign cur_pitch = pitch_q[cur];
	assign cur_start = start_q[cur];

	assign sel_o = (have2_q && (p1_q < p2_q)) ? o2_q : o1_q;
	assign sel_p = (have2_q && (p1_q < p2_q)) ? p2_q : p1_q;

	assign nv_in = (num_voices_q > pva_pkg::NV_W'(pva_pkg::MAX_VOICES))
		? CW'(pva_pkg::MAX_VOICES) : CW'(num_voices_q);

	assign out_free = !out_valid_q || m_tready;
	assign emit     = cmd.rel_cur || cmd.rel_old || cmd.start;
	assign push     = pend_q && (emit || cmd.flush);

	always_comb begin
		e_idx   = cur;
		e_pitch = cur_pitch;
		e_vel   = '0;
		if (cmd.rel_old) begin
			e_idx   = sel_o;
			e_pitch = sel_p;
		end else if (cmd.start) begin
			e_idx   = slot_q;
			e_pitch = val_q;
			e_vel   = pvel_q;
		end
	end

	assign st.cmd       = cmd_q;
	assign st.val_zero  = (val_q == '0);
	assign st.nv_zero   = (nv_q == '0);
	assign st.pv_zero   = (pvel_q == '0);
	assign st.idx_end   = (idx_q == nv_q);
	assign st.hit_match = (cur_pitch == val_q);
	assign st.hit_free  = (cur_pitch == '0);
	assign st.emit_ok   = !pend_q || out_free;

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'd0, out_vel_q, out_pitch_q, out_label_q, out_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_voices_q <= pva_pkg::NUM_VOICES_RST;
			voice_base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pva_pkg::REG_NUM_VOICES: num_voices_q <= cfg_wdata[pva_pkg::NV_W-1:0];
				pva_pkg::REG_VOICE_BASE: voice_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			cmd_q <= pva_pkg::cmd_t'(s_tdata[1:0]);
			val_q <= s_tdata[8:2];
			now_q <= s_tdata[39:9];
			nv_q  <= nv_in;
		end
		if (cmd.slot_cur)
			slot_q <= cur;
		else if (cmd.rel_old)
			slot_q <= sel_o;
		if (cmd.old_upd) begin
			if (!have1_q || (cur_start < t1_q)) begin
				o2_q <= o1_q;
				t2_q <= t1_q;
				p2_q <= p1_q;
				o1_q <= cur;
				t1_q <= cur_start;
				p1_q <= cur_pitch;
			end else if (!have2_q || (cur_start < t2_q)) begin
				o2_q <= cur;
				t2_q <= cur_start;
				p2_q <= cur_pitch;
			end
		end
		if (emit) begin
			pend_idx_q   <= pva_pkg::VIDX_W'(e_idx);
			pend_label_q <= pva_pkg::LABEL_W'(e_idx) + pva_pkg::LABEL_W'(voice_base_q);
			pend_pitch_q <= e_pitch;
			pend_vel_q   <= e_vel;
		end
		if (push) begin
			out_idx_q   <= pend_idx_q;
			out_label_q <= pend_label_q;
			out_pitch_q <= pend_pitch_q;
			out_vel_q   <= pend_vel_q;
			out_last_q  <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pva_pkg::MAX_VOICES; k++) begin
				pitch_q[k] <= '0;
				start_q[k] <= '0;
			end
			pvel_q      <= '0;
			pcnt_q      <= '0;
			idx_q       <= '0;
			have1_q     <= 1'b0;
			have2_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_vel)
				pvel_q <= val_q;
			if (cmd.rel_cur)
				pitch_q[cur] <= '0;
			if (cmd.rel_old)
				pitch_q[sel_o] <= '0;
			if (cmd.start) begin
				pitch_q[slot_q] <= val_q;
				start_q[slot_q] <= now_q;
			end
			if (cmd.clr_count)
				pcnt_q <= '0;
			else if ((cmd.rel_cur || cmd.rel_old) && (pcnt_q != '0))
				pcnt_q <= pcnt_q - 1'b1;
			else if (cmd.start && (pcnt_q != pva_pkg::PCNT_MAX))
				pcnt_q <= pcnt_q + 1'b1;
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.old_clr) begin
				have1_q <= 1'b0;
				have2_q <= 1'b0;
			end else if (cmd.old_upd) begin
				have1_q <= 1'b1;
				if (have1_q)
					have2_q <= 1'b1;
			end
			if (emit)
				pend_q <= 1'b1;
			else if (cmd.flush)
				pend_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

@@ src/poly_voice_allocator_unit.sv @@
// poly_voice_allocator_unit: top level of the polyphonic voice allocator.
// Instantiates pva_ctrl and pva_datapath; depends on pva_pkg.
//
//   channel  dir  signals                       payload
//   s_*      in   s_tvalid s_tready s_tdata     command, value, now
//   m_*      out  m_tvalid m_tready m_tdata     voice_index, voice_label, pitch, velocity
//                 m_tlast                       last
//   cfg_*    in   cfg_we cfg_index cfg_wdata    num_voices (0), voice_base (1)
//
// A note runs up to a match scan, a free scan and an oldest scan over the N active voices,
// one slot per cycle except while a result waits to be emitted; an all-off runs one such scan.
// Results leave through a one-deep holding register plus the output register, so the
// sequencer stalls only when both are full and m_tready is low. Reset clears all voices.
`timescale 1ns / 1ps

module poly_voice_allocator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pva_pkg::S_DATA_W-1:0]        s_tdata,  // command[1:0] value[8:2] now[39:9]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// voice_index[4:0] voice_label[13:5] pitch[20:14] velocity[27:21] zero[31:28]
	output logic [pva_pkg::M_DATA_W-1:0]        m_tdata,
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [pva_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pva_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	pva_pkg::ctrl_cmd_t  cmd;
	pva_pkg::dp_status_t st;

	pva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	pva_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

@@ tb/pva_tb_pkg.sv @@
// pva_tb_pkg: expected-event model and scoreboard for the voice allocator testbench.
// Depends on pva_pkg for widths, command codes and register indexes.
`timescale 1ns / 1ps

package pva_tb_pkg;
	import pva_pkg::*;

	typedef struct packed {
		logic [VIDX_W-1:0]  voice_index;
		logic [LABEL_W-1:0] voice_label;
		logic [PITCH_W-1:0] pitch;
		logic [VEL_W-1:0]   velocity;
		logic               last;
	} voice_event_t;

	class voice_alloc_scoreboard;
		logic [PITCH_W-1:0] slot_pitch[MAX_VOICES];
		logic [NOW_W-1:0]   slot_start[MAX_VOICES];
		logic [VEL_W-1:0]   armed_velocity;
		logic [NV_W-1:0]    num_voices;
		logic [BASE_W-1:0]  voice_base;
		voice_event_t       expected_events[$];
		int                 error_count;
		int                 items_seen;
		int                 events_seen;

		function new();
			for (int i = 0; i < MAX_VOICES; i++) begin
				slot_pitch[i] = '0;
				slot_start[i] = '0;
			end
			armed_velocity = '0;
			num_voices     = NUM_VOICES_RST;
			voice_base     = '0;
			error_count    = 0;
			items_seen     = 0;
			events_seen    = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NUM_VOICES: num_voices = data[NV_W-1:0];
				REG_VOICE_BASE: voice_base = data[BASE_W-1:0];
				default: ;
			endcase
		endfunction

		function void push_event(int slot, logic [PITCH_W-1:0] p, logic [VEL_W-1:0] vel);
			voice_event_t ev;
			ev.voice_index = VIDX_W'(slot);
			ev.voice_label = LABEL_W'(slot) + LABEL_W'(voice_base);
			ev.pitch       = p;
			ev.velocity    = vel;
			ev.last        = 1'b0;
			expected_events.push_back(ev);
		endfunction

		// Expected release/start events for one accepted command.
		function void predict_voice_events(cmd_t cmd, logic [VALUE_W-1:0] value,
				logic [NOW_W-1:0] stamp);
			int           active;
			int           slot;
			int           oldest;
			int           second;
			int           queued;
			bit           have_oldest;
			bit           have_second;
			bit           matched;
			voice_event_t tail;
			active = (num_voices > MAX_VOICES) ? MAX_VOICES : int'(num_voices);
			queued = expected_events.size();
			items_seen++;
			case (cmd)
				CMD_SETVEL: armed_velocity = value;
				CMD_ALLOFF: begin
					for (int i = 0; i < active; i++) begin
						if (slot_pitch[i] != '0) begin
							push_event(i, slot_pitch[i], '0);
							slot_pitch[i] = '0;
						end
					end
				end
				CMD_NOTE: begin
					if (active != 0 && value != '0) begin
						matched = 1'b0;
						for (int i = 0; i < active; i++) begin
							if (!matched && slot_pitch[i] == value) begin
								push_event(i, value, '0);
								slot_pitch[i] = '0;
								matched = 1'b1;
							end
						end
						if (armed_velocity != '0) begin
							slot = active;
							for (int i = active - 1; i >= 0; i--)
								if (slot_pitch[i] == '0)
									slot = i;
							if (slot == active) begin
								// all busy: steal oldest, or second oldest if it holds the higher pitch
								have_oldest = 1'b0;
								have_second = 1'b0;
								oldest = 0;
								second = 0;
								for (int i = 0; i < active; i++) begin
									if (!have_oldest || slot_start[i] < slot_start[oldest]) begin
										if (have_oldest) begin
											second = oldest;
											have_second = 1'b1;
										end
										oldest = i;
										have_oldest = 1'b1;
									end else if (!have_second || slot_start[i] < slot_start[second]) begin
										second = i;
										have_second = 1'b1;
									end
								end
								if (have_second && slot_pitch[oldest] < slot_pitch[second])
									oldest = second;
								push_event(oldest, slot_pitch[oldest], '0);
								slot_pitch[oldest] = '0;
								slot = oldest;
							end
							push_event(slot, value, armed_velocity);
							slot_pitch[slot] = value;
							slot_start[slot] = stamp;
						end
					end
				end
				default: ;
			endcase
			if (expected_events.size() > queued) begin
				tail = expected_events.pop_back();
				tail.last = 1'b1;
				expected_events.push_back(tail);
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				error_count++;
			end
		endfunction

		function void check_voice_event(logic [M_DATA_W-1:0] data, logic last);
			voice_event_t want;
			events_seen++;
			if (expected_events.size() == 0) begin
				$error("unexpected item: voice_index %0d pitch %0d velocity %0d",
					data[4:0], data[20:14], data[27:21]);
				error_count++;
				return;
			end
			want = expected_events.pop_front();
			compare_field("voice_index", 16'(want.voice_index), 16'(data[4:0]));
			compare_field("voice_label", 16'(want.voice_label), 16'(data[13:5]));
			compare_field("pitch", 16'(want.pitch), 16'(data[20:14]));
			compare_field("velocity", 16'(want.velocity), 16'(data[27:21]));
			compare_field("last", 16'(want.last), 16'(last));
		endfunction
	endclass

endpackage

@@ tb/poly_voice_allocator_unit_tb.sv @@
// poly_voice_allocator_unit_tb: directed and random command streams into the voice allocator,
// every output item checked against the scoreboard in pva_tb_pkg; depends on pva_pkg.
`timescale 1ns / 1ps

module poly_voice_allocator_unit_tb;
	import pva_pkg::*;
	import pva_tb_pkg::*;

	localparam int               CYCLE_LIMIT   = 400000;
	localparam int               SETTLE_CYCLES = 200;
	localparam logic [NOW_W-1:0] NOW_MAX       = 31'd2147483646;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	voice_alloc_scoreboard sb;
	int                    hold_cycles = 0;
	int                    cycle_count = 0;
	bit                    tx_gaps     = 1'b1;
	bit                    rx_gaps     = 1'b1;
	logic [NOW_W-1:0]      clock_ms    = '0;

	poly_voice_allocator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus a long hold-off when hold_cycles is loaded
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= !(rx_gaps && $urandom_range(0, 99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_voice_event(m_tdata, m_tlast);
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("poly_voice_allocator_unit_tb: done, errors");
		$finish;
	end

	function automatic logic [NOW_W-1:0] next_stamp();
		if ($urandom_range(0, 99) < 8)
			clock_ms = NOW_W'($urandom_range(0, NOW_MAX));
		else if (clock_ms > NOW_MAX - 8)
			clock_ms = '0;
		else
			clock_ms = clock_ms + NOW_W'($urandom_range(0, 3));
		return clock_ms;
	endfunction

	task automatic send_item(cmd_t cmd, logic [VALUE_W-1:0] value, logic [NOW_W-1:0] stamp);
		if (tx_gaps && $urandom_range(0, 99) < 11) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {stamp, value, cmd};
		do @(posedge clk); while (!s_tready);
		sb.predict_voice_events(cmd, value, stamp);
	endtask

	task automatic run_random(int count);
		int                 roll;
		logic [VALUE_W-1:0] v;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 62) begin
				// mostly a small pitch pool so repeats and matches are common
				if ($urandom_range(0, 3) == 0)
					v = VALUE_W'($urandom_range(0, 127));
				else
					v = VALUE_W'($urandom_range(1, 12) + 60 * $urandom_range(0, 1));
				send_item(CMD_NOTE, v, next_stamp());
			end else if (roll < 82) begin
				v = ($urandom_range(0, 3) == 0) ? '0 : VALUE_W'($urandom_range(1, 127));
				send_item(CMD_SETVEL, v, next_stamp());
			end else if (roll < 94) begin
				send_item(CMD_ALLOFF, VALUE_W'($urandom_range(0, 127)), next_stamp());
			end else begin
				send_item(CMD_UNUSED, VALUE_W'($urandom_range(0, 127)), next_stamp());
			end
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] voices, logic [CFG_DATA_W-1:0] base);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_VOICES;
		cfg_wdata <= voices;
		@(posedge clk);
		sb.write_reg(REG_NUM_VOICES, voices);
		cfg_index <= REG_VOICE_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		sb.write_reg(REG_VOICE_BASE, base);
		cfg_we <= 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_NUM_VOICES;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: two voices, base 0
		send_item(CMD_SETVEL, 7'd0, 31'd0);
		send_item(CMD_NOTE, 7'd60, 31'd5);          // zero velocity: nothing starts
		send_item(CMD_SETVEL, 7'd127, 31'd6);
		send_item(CMD_NOTE, 7'd0, 31'd7);           // pitch zero ignored
		send_item(CMD_NOTE, 7'd127, 31'd0);
		send_item(CMD_NOTE, 7'd1, NOW_MAX);
		send_item(CMD_NOTE, 7'd64, 31'd10);         // steal oldest
		send_item(CMD_NOTE, 7'd64, 31'd11);         // release match, restart
		send_item(CMD_UNUSED, 7'd127, 31'd12);
		send_item(CMD_ALLOFF, 7'd0, 31'd13);
		send_item(CMD_ALLOFF, 7'd0, 31'd14);        // nothing busy
		send_item(CMD_SETVEL, 7'd1, 31'd15);
		send_item(CMD_NOTE, 7'd10, 31'd100);
		send_item(CMD_NOTE, 7'd20, 31'd200);
		send_item(CMD_NOTE, 7'd30, 31'd300);        // oldest has lower pitch: second oldest goes
		send_item(CMD_SETVEL, 7'd0, 31'd301);
		send_item(CMD_NOTE, 7'd30, 31'd302);        // release only
		send_item(CMD_SETVEL, 7'd90, 31'd303);
		send_item(CMD_NOTE, 7'd40, 31'd304);
		send_item(CMD_ALLOFF, 7'd0, 31'd400);
		send_item(CMD_NOTE, 7'd7, 31'd500);
		send_item(CMD_NOTE, 7'd6, 31'd500);
		send_item(CMD_NOTE, 7'd8, 31'd600);         // equal start times: lower slot is older
		run_random(20);
		settle();

		// one voice; slot 1 may stay busy outside the active range
		configure(8'd1, 8'd255);
		send_item(CMD_SETVEL, 7'd5, next_stamp());
		send_item(CMD_NOTE, 7'd70, next_stamp());
		send_item(CMD_NOTE, 7'd71, next_stamp());
		send_item(CMD_ALLOFF, 7'd0, next_stamp());
		run_random(20);
		settle();

		configure(8'd0, 8'd17);
		run_random(15);
		settle();

		// all 32 voices, no gaps, then a long receiver hold during a full all-off
		configure(8'd32, 8'd200);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_item(CMD_ALLOFF, 7'd0, next_stamp());
		send_item(CMD_SETVEL, 7'd100, next_stamp());
		for (int i = 0; i < MAX_VOICES; i++)
			send_item(CMD_NOTE, VALUE_W'(20 + i), next_stamp());
		hold_cycles = 400;
		send_item(CMD_ALLOFF, 7'd0, next_stamp());
		for (int i = 0; i < 5; i++)
			send_item(CMD_NOTE, VALUE_W'(90 + i), next_stamp());
		run_random(20);
		settle();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		// out-of-range voice count acts as the maximum; largest label
		configure(8'hFF, 8'hFF);
		run_random(20);
		settle();

		configure(8'd4, 8'd0);
		run_random(25);
		settle();

		configure(8'd8, 8'd128);
		run_random(15);
		settle();

		$display("summary: %0d commands over seven voice-count/base settings, %0d items checked",
			sb.items_seen, sb.events_seen);
		if (sb.error_count == 0 && sb.expected_events.size() == 0)
			$display("poly_voice_allocator_unit_tb: done, clean");
		else
			$display("poly_voice_allocator_unit_tb: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
src/pva_pkg.sv
src/pva_ctrl.sv
src/pva_datapath.sv
src/poly_voice_allocator_unit.sv
tb/pva_tb_pkg.sv
tb/poly_voice_allocator_unit_tb.sv
